FILE: design/fft_pkg.sv
`default_nettype none
package fft_pkg;
  typedef enum logic [3:0] {
    ST_LOAD, ST_RD_LO, ST_RD_HI, ST_MUL, ST_WR_LO, ST_WR_HI,
    ST_EMIT_RD, ST_EMIT_WAIT, ST_EMIT_OUT
  } state_e;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned TW_BITS   = 16;
  localparam int unsigned ROM_LOG2  = 6;

  localparam logic [0:0] REG_POINTS_LOG2  = 1'b0;
  localparam logic [0:0] REG_INVERSE_MODE = 1'b1;

  // Quarter-wave sine, Q1.15, round(32768*sin(2*pi*k/64)), k = 0..16, capped at 32767.
  function automatic logic [15:0] sine_rom(input logic [4:0] k);
    logic [15:0] v;
    begin
      case (k)
        5'd0: v = 16'd0;
        5'd1: v = 16'd3212;
        5'd2: v = 16'd6393;
        5'd3: v = 16'd9512;
        5'd4: v = 16'd12540;
        5'd5: v = 16'd15447;
        5'd6: v = 16'd18205;
        5'd7: v = 16'd20788;
        5'd8: v = 16'd23170;
        5'd9: v = 16'd25330;
        5'd10: v = 16'd27246;
        5'd11: v = 16'd28899;
        5'd12: v = 16'd30274;
        5'd13: v = 16'd31357;
        5'd14: v = 16'd32138;
        5'd15: v = 16'd32610;
        5'd16: v = 16'd32767;
        default: v = 16'd0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [15:0] rom_cos(input logic [4:0] k);
    logic signed [15:0] v;
    begin
      if (k <= 5'd16) v = signed'(sine_rom(5'd16 - k));
      else            v = -signed'(sine_rom(k - 5'd16));
      return v;
    end
  endfunction

  function automatic logic signed [15:0] rom_sin(input logic [4:0] k);
    logic signed [15:0] v;
    begin
      if (k <= 5'd16) v = signed'(sine_rom(k));
      else            v = signed'(sine_rom(5'd0 - k));
      return v;
    end
  endfunction

  // Rounded Q1.15 product: (a*w + 2^14) >>> 15.
  function automatic logic signed [31:0] round_mul(input logic signed [31:0] a,
                                                   input logic signed [15:0] w);
    logic signed [47:0] p;
    begin
      p = 48'(a) * 48'(w) + 48'sd16384;
      return 32'(p >>> 15);
    end
  endfunction
endpackage
`default_nettype wire

FILE: design/fft_ram.sv
`default_nettype none
module fft_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: design/fft_bfly.sv
`default_nettype none
// Two-stage butterfly: register the four rounded products, then add/subtract.
module fft_bfly (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] ar_i,
  input  wire logic signed [31:0] ai_i,
  input  wire logic signed [31:0] br_i,
  input  wire logic signed [31:0] bi_i,
  input  wire logic signed [15:0] wr_i,
  input  wire logic signed [15:0] wi_i,
  output logic signed [31:0]      lo_r_o,
  output logic signed [31:0]      lo_i_o,
  output logic signed [31:0]      hi_r_o,
  output logic signed [31:0]      hi_i_o
);
  logic signed [31:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, ar_q, ai_q;
  logic signed [31:0] tr, ti;

  always_ff @(posedge clk_i) begin
    p_rr_q <= fft_pkg::round_mul(br_i, wr_i);
    p_ii_q <= fft_pkg::round_mul(bi_i, wi_i);
    p_ri_q <= fft_pkg::round_mul(bi_i, wr_i);
    p_ir_q <= fft_pkg::round_mul(br_i, wi_i);
    ar_q   <= ar_i;
    ai_q   <= ai_i;
  end

  assign tr     = p_rr_q - p_ii_q;
  assign ti     = p_ri_q + p_ir_q;
  assign lo_r_o = ar_q + tr;
  assign lo_i_o = ai_q + ti;
  assign hi_r_o = ar_q - tr;
  assign hi_i_o = ai_q - ti;
endmodule
`default_nettype wire

FILE: design/radix2_complex_fft.sv
`default_nettype none
// Radix-2 decimation-in-time complex FFT, fixed point, 4..64 points.
// Input stream s_axis: one complex sample per transfer. Each sample is
// written at the bit-reversed position of its arrival index. When the
// N-th sample of a frame arrives, input stalls (s_axis_tready low) and
// the block runs the in-place transform, then emits all N bins in
// natural order on m_axis, tlast on the final bin, tuser = bin number.
// Configuration: cfg_we_i with cfg_addr_i 0 (points_log2, clamped to the
// supported range) or 1 (inverse_mode). Writing points_log2 restarts
// the partly loaded frame. Write only while idle.
// Sequencing: loading accepts one sample per cycle. Each butterfly goes
// through the single work memory as read low word, read high word,
// multiply, write low word, write high word; inverse mode applies its
// 1/N scaling on the way out. Each bin is read from the work memory,
// registered in the output register (scaled in inverse mode) and offered on
// m_axis; the next bin is not read until the receiver takes it, and a stalled
// bin is held in the output register.
// Reset empties the load counter and sets 64 points (clamped to
// MAX_POINTS), forward; the work memory needs no clearing since every
// frame writes all entries before reading any.
module radix2_complex_fft #(
  parameter int unsigned MAX_POINTS  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // [SAMPLE_BITS-1:0] sample_real, [2*SAMPLE_BITS-1:SAMPLE_BITS] sample_imag
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // [31:0] bin_real, [63:32] bin_imag
  output logic [63:0]                     m_axis_tdata,
  // [5:0] bin_number
  output logic [5:0]                      m_axis_tuser,
  output logic                            m_axis_tlast,
  input  wire logic                       cfg_we_i,
  input  wire logic [0:0]                 cfg_addr_i,
  input  wire logic [2:0]                 cfg_wdata_i
);
  localparam int unsigned AW          = $clog2(MAX_POINTS);
  localparam int unsigned PMAX        = $clog2(MAX_POINTS + 1) - 1;
  localparam int unsigned MAXP        = (PMAX > 6) ? 6 : PMAX;
  localparam int unsigned ROM_LOG2_M1 = fft_pkg::ROM_LOG2 - 1;

  logic [2:0]    plog2_q;
  logic          inv_q, inv_frame_q;
  logic [AW:0]   cnt_q;
  fft_pkg::state_e st_q, st_d;
  logic [2:0]    stage_q;
  logic [AW-1:0] bf_q;
  logic [AW-1:0] emit_q;
  logic [2:0]    p_eff;
  logic [AW:0]   n_pts;

  always_comb begin
    p_eff = plog2_q;
    if (p_eff < 3'd2) p_eff = 3'd2;
    if (p_eff > 3'(MAXP)) p_eff = 3'(MAXP);
  end
  assign n_pts = (AW+1)'(1) << p_eff;

  function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] k, input logic [2:0] p);
    logic [AW-1:0] r;
    begin
      r = '0;
      for (int b = 0; b < AW; b++)
        if (b < int'(p)) r[int'(p) - 1 - b] = k[b];
      return r;
    end
  endfunction

  // Butterfly addressing: group j = bf mod half, block = bf / half.
  logic [AW-1:0] half_m, jj, lo_a, hi_a;
  logic [4:0]    tw_k;
  assign half_m = AW'((AW+1)'(1) << stage_q) - AW'(1);
  assign jj     = bf_q & half_m;
  assign lo_a   = ((bf_q & ~half_m) << 1) | jj;
  assign hi_a   = lo_a | (half_m + AW'(1));
  assign tw_k   = 5'((32'(jj) << (ROM_LOG2_M1 - 32'(stage_q))) & 32'd31);

  // Work memory: one packed entry {imag, real} per point.
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [63:0]   wd, rd;

  fft_ram #(.Width(64), .Depth(2**AW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rd));

  logic signed [15:0] wr_s, wi_s;
  assign wr_s = fft_pkg::rom_cos(tw_k);
  assign wi_s = inv_frame_q ? fft_pkg::rom_sin(tw_k) : -fft_pkg::rom_sin(tw_k);

  // Low word is held while the high word is read; the high result is held in
  // hi_q while the low result takes the write port.
  logic [63:0] a_q, hi_q;

  logic signed [31:0] lo_r, lo_i, hi_r, hi_i;
  fft_bfly u_bfly (
    .clk_i,
    .ar_i(a_q[31:0]), .ai_i(a_q[63:32]), .br_i(rd[31:0]), .bi_i(rd[63:32]),
    .wr_i(wr_s), .wi_i(wi_s),
    .lo_r_o(lo_r), .lo_i_o(lo_i), .hi_r_o(hi_r), .hi_i_o(hi_i));

  logic signed [31:0] s_re, s_im;
  assign s_re = 32'(signed'(s_axis_tdata[SAMPLE_BITS-1:0]));
  assign s_im = 32'(signed'(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));

  logic in_xfer, last_bf, last_stage, frame_done, len_wr;
  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign last_bf    = ({1'b0, bf_q} == (n_pts >> 1) - (AW+1)'(1));
  assign last_stage = (stage_q == p_eff - 3'd1);
  assign frame_done = (cnt_q == n_pts - (AW+1)'(1));
  assign len_wr     = cfg_we_i && (cfg_addr_i == fft_pkg::REG_POINTS_LOG2);
  assign s_axis_tready = (st_q == fft_pkg::ST_LOAD);

  always_comb begin
    ra = lo_a;
    we = 1'b0;
    wa = bitrev(cnt_q[AW-1:0], p_eff);
    wd = {s_im, s_re};
    case (st_q)
      fft_pkg::ST_LOAD:    we = in_xfer;
      fft_pkg::ST_RD_HI:   ra = hi_a;
      fft_pkg::ST_WR_LO: begin
        we = 1'b1;
        wa = lo_a;
        wd = {lo_i, lo_r};
      end
      fft_pkg::ST_WR_HI: begin
        we = 1'b1;
        wa = hi_a;
        wd = hi_q;
      end
      fft_pkg::ST_EMIT_RD: ra = emit_q;
      default: ;
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      fft_pkg::ST_LOAD:
        if (in_xfer && frame_done && !len_wr) st_d = fft_pkg::ST_RD_LO;
      fft_pkg::ST_RD_LO:     st_d = fft_pkg::ST_RD_HI;
      fft_pkg::ST_RD_HI:     st_d = fft_pkg::ST_MUL;
      fft_pkg::ST_MUL:       st_d = fft_pkg::ST_WR_LO;
      fft_pkg::ST_WR_LO:     st_d = fft_pkg::ST_WR_HI;
      fft_pkg::ST_WR_HI:     st_d = (last_bf && last_stage) ? fft_pkg::ST_EMIT_RD
                                                            : fft_pkg::ST_RD_LO;
      fft_pkg::ST_EMIT_RD:   st_d = fft_pkg::ST_EMIT_WAIT;
      fft_pkg::ST_EMIT_WAIT: st_d = fft_pkg::ST_EMIT_OUT;
      fft_pkg::ST_EMIT_OUT:
        if (m_axis_tready)
          st_d = m_axis_tlast ? fft_pkg::ST_LOAD : fft_pkg::ST_EMIT_RD;
      default: st_d = fft_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= fft_pkg::ST_LOAD;
      plog2_q <= 3'd6;
      inv_q   <= 1'b0;
      inv_frame_q <= 1'b0;
      cnt_q   <= '0;
      stage_q <= '0;
      bf_q    <= '0;
      emit_q  <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        if (cfg_addr_i == fft_pkg::REG_POINTS_LOG2) begin
          plog2_q <= cfg_wdata_i;
        end else begin
          inv_q <= cfg_wdata_i[0];
        end
      end
      if (len_wr) begin
        cnt_q <= '0;
      end else if (in_xfer) begin
        if (frame_done) begin
          cnt_q       <= '0;
          inv_frame_q <= inv_q;
          stage_q     <= '0;
          bf_q        <= '0;
          emit_q      <= '0;
        end else begin
          cnt_q <= cnt_q + (AW+1)'(1);
        end
      end
      if (st_q == fft_pkg::ST_WR_HI) begin
        if (last_bf) begin
          bf_q    <= '0;
          stage_q <= stage_q + 3'd1;
        end else begin
          bf_q <= bf_q + AW'(1);
        end
      end
      if (st_q == fft_pkg::ST_EMIT_OUT && m_axis_tready)
        emit_q <= emit_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == fft_pkg::ST_RD_HI) a_q <= rd;
    if (st_q == fft_pkg::ST_WR_LO) hi_q <= {hi_i, hi_r};
  end

  // Output register with inverse scaling.
  logic [2:0]         psh;
  logic signed [31:0] o_re, o_im, bias;
  assign psh  = p_eff;
  assign bias = 32'sd1 <<< (psh - 3'd1);
  assign o_re = inv_frame_q ? ((signed'(rd[31:0]) + bias) >>> psh) : signed'(rd[31:0]);
  assign o_im = inv_frame_q ? ((signed'(rd[63:32]) + bias) >>> psh)
                            : signed'(rd[63:32]);

  logic [63:0] out_q;
  always_ff @(posedge clk_i) begin
    if (st_q == fft_pkg::ST_EMIT_WAIT) out_q <= {o_im, o_re};
  end

  assign m_axis_tvalid = (st_q == fft_pkg::ST_EMIT_OUT);
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = 6'(emit_q);
  assign m_axis_tlast  = ({1'b0, emit_q} == n_pts - (AW+1)'(1));

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("output and input active together");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled bin not held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("no return to load after frame");
endmodule
`default_nettype wire

FILE: tb/radix2_complex_fft_tb.sv
`default_nettype none
module radix2_complex_fft_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200_000;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [5:0]         number;
    logic               last;
  } bin_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire logic   s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  wire logic   m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire logic [63:0] m_axis_tdata;
  wire logic [5:0]  m_axis_tuser;
  wire logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_addr_i = fft_pkg::REG_POINTS_LOG2;
  logic [2:0]  cfg_wdata_i = '0;

  radix2_complex_fft dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: its own copy of the work memory, load count and registers.
  logic signed [63:0] pred_re [64];
  logic signed [63:0] pred_im [64];
  int unsigned        samples_loaded;
  logic [2:0]         length_reg;
  logic               inverse_reg;
  bin_t               expected_bins [$];
  int unsigned        error_count;
  int unsigned        bins_seen;
  int unsigned        frames_done;
  longint unsigned    cycle_count;

  function automatic int unsigned active_log2();
    int unsigned p;
    p = length_reg;
    if (p < 2) p = 2;
    if (p > 6) p = 6;
    return p;
  endfunction

  function automatic logic signed [63:0] scaled_product(logic signed [63:0] a,
                                                        logic signed [15:0] w);
    logic signed [63:0] prod;
    prod = a * 64'(w) + 64'sd16384;
    return prod >>> 15;
  endfunction

  function automatic logic signed [15:0] quarter_sine(int unsigned k);
    int unsigned q [17] = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
                            25330, 27246, 28899, 30274, 31357, 32138, 32610, 32767};
    return 16'(q[k]);
  endfunction

  // Run the in-place butterflies over the bit-reversed store, then queue the bins.
  task automatic compute_spectrum(int unsigned p);
    int unsigned n, half, k, lo, hi;
    logic signed [15:0] wr, wi;
    logic signed [63:0] tr, ti, bias;
    n = 1 << p;
    for (int s = 0; s < p; s++) begin
      half = 1 << s;
      for (int j = 0; j < half; j++) begin
        k = (j << (5 - s)) & 31;
        wr = (k <= 16) ? quarter_sine(16 - k) : -quarter_sine(k - 16);
        wi = (k <= 16) ? quarter_sine(k) : quarter_sine(32 - k);
        if (!inverse_reg) wi = -wi;
        for (int i = j; i + half < n; i += 2 * half) begin
          lo = i;
          hi = i + half;
          tr = scaled_product(pred_re[hi], wr) - scaled_product(pred_im[hi], wi);
          ti = scaled_product(pred_im[hi], wr) + scaled_product(pred_re[hi], wi);
          pred_re[hi] = pred_re[lo] - tr;
          pred_im[hi] = pred_im[lo] - ti;
          pred_re[lo] = pred_re[lo] + tr;
          pred_im[lo] = pred_im[lo] + ti;
        end
      end
    end
    bias = 64'sd1 <<< (p - 1);
    for (int i = 0; i < n; i++) begin
      bin_t b;
      if (inverse_reg) begin
        pred_re[i] = (pred_re[i] + bias) >>> p;
        pred_im[i] = (pred_im[i] + bias) >>> p;
      end
      b.re = pred_re[i][31:0];
      b.im = pred_im[i][31:0];
      b.number = 6'(i);
      b.last = (i == n - 1);
      expected_bins.push_back(b);
    end
    frames_done++;
  endtask

  // Place an accepted sample and start the transform once the frame is full.
  task automatic load_sample(logic [31:0] word);
    int unsigned p, n, pos;
    p = active_log2();
    n = 1 << p;
    if (samples_loaded >= n) samples_loaded = 0;
    pos = 0;
    for (int b = 0; b < p; b++) pos |= ((samples_loaded >> b) & 1) << (p - 1 - b);
    pred_re[pos] = 64'(signed'(word[15:0]));
    pred_im[pos] = 64'(signed'(word[31:16]));
    samples_loaded++;
    if (samples_loaded == n) begin
      samples_loaded = 0;
      compute_spectrum(p);
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at bin %0d: %s got %0h want %0h", bins_seen, what, got, want);
    error_count++;
  endtask

  // Drive one sample, with a random gap ahead of it when the burst runs out.
  int unsigned burst_left;
  task automatic send_sample(logic [31:0] word);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    load_sample(word);
    @(negedge clk_i);
  endtask

  // Drop the input, then wait out every pending bin plus the tail of the pipeline.
  task automatic drain_bins();
    s_axis_tvalid <= 1'b0;
    while (expected_bins.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_register(logic [0:0] index, logic [2:0] value);
    drain_bins();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= index;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == fft_pkg::REG_POINTS_LOG2) begin
      length_reg = value;
      samples_loaded = 0;
    end else begin
      inverse_reg = value[0];
    end
  endtask

  function automatic logic [31:0] random_sample(int unsigned flavor);
    logic [15:0] r, i;
    case (flavor)
      0: begin r = 16'h7fff; i = 16'h8000; end
      1: begin r = 16'h8000; i = 16'h7fff; end
      default: begin r = $urandom; i = $urandom; end
    endcase
    return {i, r};
  endfunction

  task automatic send_frames(int unsigned count, int unsigned flavor);
    for (int f = 0; f < count; f++)
      for (int s = 0; s < (1 << active_log2()); s++) send_sample(random_sample(flavor));
  endtask

  // Directed: extreme samples, impulse and full-scale frames at the smallest size.
  task automatic test_directed_extremes();
    write_register(fft_pkg::REG_POINTS_LOG2, 3'd2);
    write_register(fft_pkg::REG_INVERSE_MODE, 3'd0);
    send_sample(32'h0000_7fff);
    repeat (3) send_sample(32'h0000_0000);
    send_frames(1, 0);
    send_frames(1, 1);
    write_register(fft_pkg::REG_INVERSE_MODE, 3'd1);
    send_frames(1, 0);
    send_sample(32'h8000_8000);
    repeat (3) send_sample(32'hffff_ffff);
  endtask

  // Lengths below 2 and above 6 clamp; a length write drops a partial frame.
  task automatic test_length_clamp();
    write_register(fft_pkg::REG_POINTS_LOG2, 3'd0);
    send_frames(1, 2);
    write_register(fft_pkg::REG_POINTS_LOG2, 3'd1);
    send_sample(random_sample(2));
    write_register(fft_pkg::REG_POINTS_LOG2, 3'd7);
    send_frames(1, 2);
  endtask

  // Direction is taken when the last sample arrives, so flip it mid-frame.
  task automatic test_direction_mid_frame();
    write_register(fft_pkg::REG_POINTS_LOG2, 3'd3);
    write_register(fft_pkg::REG_INVERSE_MODE, 3'd0);
    for (int s = 0; s < 4; s++) send_sample(random_sample(2));
    write_register(fft_pkg::REG_INVERSE_MODE, 3'd1);
    for (int s = 0; s < 4; s++) send_sample(random_sample(2));
  endtask

  // Random frames over every size and direction, mostly small ones.
  task automatic test_random_frames();
    int unsigned sent;
    sent = 0;
    while (sent < 56) begin
      write_register(fft_pkg::REG_POINTS_LOG2,
                     3'($urandom_range(0, 9) == 0 ? 6 : $urandom_range(2, 5)));
      write_register(fft_pkg::REG_INVERSE_MODE, 3'($urandom_range(0, 1)));
      send_frames(1, 2);
      sent += 1 << active_log2();
      // now and then, hold the sender until every bin of the frame is out
      if ($urandom_range(0, 3) == 0) drain_bins();
    end
  endtask

  // Receiver backpressure: stretches of steady readiness and random stalls.
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else if ((cycle_count / 300) % 3 == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // Compare each bin transfer against the oldest expectation.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bins.size() == 0) begin
        report_mismatch("unexpected bin", 64'(m_axis_tuser), 64'd0);
      end else begin
        bin_t want;
        want = expected_bins.pop_front();
        if (m_axis_tdata[31:0] !== want.re) report_mismatch("real", m_axis_tdata[31:0], want.re);
        if (m_axis_tdata[63:32] !== want.im) report_mismatch("imag", m_axis_tdata[63:32], want.im);
        if (m_axis_tuser !== want.number) report_mismatch("number", m_axis_tuser, want.number);
        if (m_axis_tlast !== want.last) report_mismatch("last", m_axis_tlast, want.last);
      end
      bins_seen++;
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    error_count = 0;
    bins_seen = 0;
    frames_done = 0;
    burst_left = 0;
    samples_loaded = 0;
    length_reg = 3'd6;
    inverse_reg = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed_extremes();
    test_length_clamp();
    test_direction_mid_frame();
    test_random_frames();
    drain_bins();
    $display("covered %0d frames, %0d bins, sizes 4..64 both directions with clamped lengths",
             frames_done, bins_seen);
    if (error_count == 0 && expected_bins.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d bins never seen", error_count, expected_bins.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
design/fft_pkg.sv
design/fft_ram.sv
design/fft_bfly.sv
design/radix2_complex_fft.sv
tb/radix2_complex_fft_tb.sv
